// ===== src/ps2mt_pkg.sv =====
// Shared types, constants and helper functions for the PS/2 mouse packet tracker.
// No dependencies; every other file of the block imports this package.
package ps2mt_pkg;

  // Coordinate and configuration widths
  localparam int COORD_WIDTH    = 12;
  localparam int SIZE_WIDTH     = 13;
  localparam int SUM_WIDTH      = COORD_WIDTH + 2;
  localparam int CLAMP_WIDTH    = (COORD_WIDTH > SIZE_WIDTH) ? COORD_WIDTH : SIZE_WIDTH;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = SIZE_WIDTH;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_EXTENDED_MODE = 2'd0,
    CFG_VIEW_WIDTH    = 2'd1,
    CFG_VIEW_HEIGHT   = 2'd2
  } cfg_reg_e;

  // Controller status and first-byte bit positions
  localparam int ST_FULL_BIT  = 0;
  localparam int ST_AUX_BIT   = 5;
  localparam int B0_LEFT_BIT  = 0;
  localparam int B0_SYNC_BIT  = 3;
  localparam int B0_XSIGN_BIT = 4;
  localparam int B0_YSIGN_BIT = 5;

  // Wheel nibble codes and scroll directions
  localparam logic [3:0]        WHEEL_UP_NIB   = 4'h1;
  localparam logic [3:0]        WHEEL_DOWN_NIB = 4'hF;
  localparam logic signed [1:0] SCROLL_NONE    = 2'sb00;
  localparam logic signed [1:0] SCROLL_UP      = 2'sb01;
  localparam logic signed [1:0] SCROLL_DOWN    = 2'sb11;

  // Byte positions inside a packet
  localparam logic [1:0] POS_FIRST      = 2'd0;
  localparam logic [1:0] POS_LAST_STD   = 2'd2;
  localparam logic [1:0] POS_LAST_WHEEL = 2'd3;

  // Reset values
  localparam logic [SIZE_WIDTH-1:0]  RST_VIEW_WIDTH  = SIZE_WIDTH'(800);
  localparam logic [SIZE_WIDTH-1:0]  RST_VIEW_HEIGHT = SIZE_WIDTH'(600);
  localparam logic [COORD_WIDTH-1:0] RST_POS_X       = COORD_WIDTH'(400);
  localparam logic [COORD_WIDTH-1:0] RST_POS_Y       = COORD_WIDTH'(300);

  // Configuration as seen by the datapath
  typedef struct packed {
    logic                  extended_mode;
    logic [SIZE_WIDTH-1:0] view_width;
    logic [SIZE_WIDTH-1:0] view_height;
  } cfg_t;

  // Registered input beat
  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } beat_t;

  // Handshake between the input register and the tracker stage
  typedef struct packed {
    logic valid;
  } stage_ctrl_t;

  // Clamp a signed position sum to 0 .. min(size-1, coordinate max); size 0 pins at 0
  function automatic logic [COORD_WIDTH-1:0] clamp_axis(
    input logic signed [SUM_WIDTH-1:0] v,
    input logic [SIZE_WIDTH-1:0]       size
  );
    logic [CLAMP_WIDTH-1:0] lim_full;
    logic [CLAMP_WIDTH-1:0] cap;
    logic [COORD_WIDTH-1:0] lim;
    logic [SUM_WIDTH-1:0]   v_u;
    logic [COORD_WIDTH-1:0] res;
    lim_full = (size == '0) ? '0 : CLAMP_WIDTH'(size - SIZE_WIDTH'(1));
    cap      = CLAMP_WIDTH'({COORD_WIDTH{1'b1}});
    lim      = (lim_full > cap) ? cap[COORD_WIDTH-1:0] : lim_full[COORD_WIDTH-1:0];
    v_u      = $unsigned(v);
    if (v[SUM_WIDTH-1]) begin
      res = '0;
    end else if (v_u > {2'b00, lim}) begin
      res = lim;
    end else begin
      res = v_u[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/ps2mt_ifs.sv =====
// Valid/ready channel interfaces for the mouse tracker: input byte beats and result beats.
// Depends on ps2mt_pkg for the coordinate width.
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] data_byte;

  modport source (output valid, status_byte, data_byte, input ready);
  modport sink   (input valid, status_byte, data_byte, output ready);
endinterface

interface ps2mt_result_if;
  import ps2mt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   packet_done;
  logic                   byte_dropped;
  logic [COORD_WIDTH-1:0] cursor_x;
  logic [COORD_WIDTH-1:0] cursor_y;
  logic                   left_pressed;
  logic signed [1:0]      scroll_dir;

  modport source (output valid, packet_done, byte_dropped, cursor_x, cursor_y,
                  left_pressed, scroll_dir, input ready);
  modport sink   (input valid, packet_done, byte_dropped, cursor_x, cursor_y,
                  left_pressed, scroll_dir, output ready);
endinterface

// ===== src/ps2mt_cfg_regs.sv =====
// Configuration registers of the mouse tracker: wheel mode and screen size.
// Depends on ps2mt_pkg.
module ps2mt_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ps2mt_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [ps2mt_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  output ps2mt_pkg::cfg_t                      cfg_o
);
  import ps2mt_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXTENDED_MODE: cfg_d.extended_mode = cfg_data_i[0];
        CFG_VIEW_WIDTH:    cfg_d.view_width    = cfg_data_i[SIZE_WIDTH-1:0];
        CFG_VIEW_HEIGHT:   cfg_d.view_height   = cfg_data_i[SIZE_WIDTH-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extended_mode <= 1'b0;
      cfg_q.view_width    <= RST_VIEW_WIDTH;
      cfg_q.view_height   <= RST_VIEW_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ps2mt_in_stage.sv =====
// Input register of the mouse tracker: captures one status/data beat per cycle while its slot is free.
// Depends on ps2mt_pkg and ps2mt_byte_if.
module ps2mt_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ps2mt_byte_if.sink               byte_i,
  input  logic                     advance_i,
  output ps2mt_pkg::stage_ctrl_t   ctrl_o,
  output ps2mt_pkg::beat_t         beat_o
);
  import ps2mt_pkg::*;

  logic  valid_q;
  beat_t beat_q;

  // Free slot when empty or when the held beat moves on this cycle
  assign byte_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      valid_q <= byte_i.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      beat_q.status_byte <= byte_i.status_byte;
      beat_q.data_byte   <= byte_i.data_byte;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign beat_o       = beat_q;

endmodule

// ===== src/ps2mt_tracker.sv =====
// Packet assembly, cursor update and result register of the mouse tracker.
// Depends on ps2mt_pkg and ps2mt_result_if.
module ps2mt_tracker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ps2mt_pkg::stage_ctrl_t ctrl_i,
  input  ps2mt_pkg::beat_t       beat_i,
  input  ps2mt_pkg::cfg_t        cfg_i,
  output logic                   advance_o,
  ps2mt_result_if.source         result_o
);
  import ps2mt_pkg::*;

  // Tracking state
  logic [1:0]             byte_pos_q, byte_pos_d;
  logic [7:0]             store_q [3];
  logic [COORD_WIDTH-1:0] pos_x_q, pos_x_d;
  logic [COORD_WIDTH-1:0] pos_y_q, pos_y_d;
  logic                   left_q, left_d;
  logic signed [1:0]      wheel_q, wheel_d;

  // Result register
  logic                   out_valid_q;
  logic                   done_q, dropped_q;
  logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic                   out_left_q;
  logic signed [1:0]      out_wheel_q;

  logic                        take;
  logic                        store_we;
  logic                        done, dropped;
  logic [1:0]                  last_pos;
  logic [7:0]                  b0, b1, b2;
  logic signed [SUM_WIDTH-1:0] dx, dy, nx, ny;

  // Move a beat into the result register when it is empty or being drained
  assign advance_o = ctrl_i.valid && (!out_valid_q || result_o.ready);

  // Delta and new position
  assign take     = beat_i.status_byte[ST_FULL_BIT] && beat_i.status_byte[ST_AUX_BIT];
  assign last_pos = cfg_i.extended_mode ? POS_LAST_WHEEL : POS_LAST_STD;
  assign b0       = store_q[0];
  assign b1       = store_q[1];
  assign b2       = cfg_i.extended_mode ? store_q[2] : beat_i.data_byte;
  assign dx       = SUM_WIDTH'($signed({b0[B0_XSIGN_BIT], b1}));
  assign dy       = SUM_WIDTH'($signed({b0[B0_YSIGN_BIT], b2}));
  assign nx       = $signed({2'b00, pos_x_q}) + dx;
  assign ny       = $signed({2'b00, pos_y_q}) - dy;

  // Next state for one accepted byte
  always_comb begin
    byte_pos_d = byte_pos_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    left_d     = left_q;
    wheel_d    = wheel_q;
    store_we   = 1'b0;
    done       = 1'b0;
    dropped    = 1'b0;
    if (advance_o && take) begin
      if (byte_pos_q == POS_FIRST && !beat_i.data_byte[B0_SYNC_BIT]) begin
        dropped = 1'b1;
      end else if (byte_pos_q < last_pos) begin
        store_we   = 1'b1;
        byte_pos_d = byte_pos_q + 2'd1;
      end else begin
        done       = 1'b1;
        byte_pos_d = POS_FIRST;
        left_d     = b0[B0_LEFT_BIT];
        if (cfg_i.extended_mode) begin
          if (beat_i.data_byte[3:0] == WHEEL_UP_NIB) begin
            wheel_d = SCROLL_UP;
          end else if (beat_i.data_byte[3:0] == WHEEL_DOWN_NIB) begin
            wheel_d = SCROLL_DOWN;
          end
        end
        pos_x_d = clamp_axis(nx, cfg_i.view_width);
        pos_y_d = clamp_axis(ny, cfg_i.view_height);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= POS_FIRST;
      pos_x_q     <= RST_POS_X;
      pos_y_q     <= RST_POS_Y;
      left_q      <= 1'b0;
      wheel_q     <= SCROLL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      left_q     <= left_d;
      wheel_q    <= wheel_d;
      if (advance_o) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Packet byte store, written at the current byte position
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      case (byte_pos_q)
        2'd0:    store_q[0] <= beat_i.data_byte;
        2'd1:    store_q[1] <= beat_i.data_byte;
        2'd2:    store_q[2] <= beat_i.data_byte;
        default: ;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      done_q      <= done;
      dropped_q   <= dropped;
      out_x_q     <= pos_x_d;
      out_y_q     <= pos_y_d;
      out_left_q  <= left_d;
      out_wheel_q <= wheel_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.packet_done  = done_q;
  assign result_o.byte_dropped = dropped_q;
  assign result_o.cursor_x     = out_x_q;
  assign result_o.cursor_y     = out_y_q;
  assign result_o.left_pressed = out_left_q;
  assign result_o.scroll_dir   = out_wheel_q;

endmodule

// ===== src/ps2_mouse_packet_tracker_top.sv =====
// Top level of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg, ps2mt_ifs, ps2mt_cfg_regs, ps2mt_in_stage and ps2mt_tracker.
//
// Every accepted status/data beat yields exactly one result beat: the beat waits in the
// input register, then the tracker stage updates the cursor and loads the result
// register, which offers it on result_o. A byte is used only when the status shows
// output full and auxiliary data; packets are 3 bytes, or 4 with the wheel byte when
// extended_mode is set, and a first byte without bit 3 is dropped. The block takes one
// beat per clock cycle; a result waiting on the output holds the tracker stage, and
// byte_i.ready then stays high only while the input register is empty (one more beat
// at most). Write the configuration registers only while no beat is in flight.
module ps2_mouse_packet_tracker_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  ps2mt_byte_if.sink                           byte_i,
  ps2mt_result_if.source                       result_o,
  input  logic                                 cfg_we_i,
  input  logic [ps2mt_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [ps2mt_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);
  import ps2mt_pkg::*;

  cfg_t        cfg;
  stage_ctrl_t stage_ctrl;
  beat_t       beat;
  logic        advance;

  ps2mt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ps2mt_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .ctrl_o    (stage_ctrl),
    .beat_o    (beat)
  );

  ps2mt_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stage_ctrl),
    .beat_i    (beat),
    .cfg_i     (cfg),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

// ===== src/ps2mt_checker.sv =====
// Port-level checks for the mouse tracker, attached to the top level by bind.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker_top.
module ps2mt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                packet_done_i,
  input logic                                byte_dropped_i,
  input logic [ps2mt_pkg::COORD_WIDTH-1:0]   cursor_x_i,
  input logic [ps2mt_pkg::COORD_WIDTH-1:0]   cursor_y_i,
  input logic                                left_pressed_i,
  input logic signed [1:0]                   scroll_dir_i
);
  import ps2mt_pkg::*;

  logic out_beat;
  assign out_beat = out_valid_i && out_ready_i;

  // Stalled result beat stays valid and keeps its cursor and packet_done
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cursor_x_i)
      && $stable(cursor_y_i) && $stable(packet_done_i))
    else $error("result beat changed while stalled");

  // A byte never both completes a packet and is dropped
  a_done_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(packet_done_i && byte_dropped_i))
    else $error("packet_done and byte_dropped both set");

  // Scroll direction is up, down or none
  a_scroll_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (scroll_dir_i == SCROLL_NONE || scroll_dir_i == SCROLL_UP
      || scroll_dir_i == SCROLL_DOWN))
    else $error("scroll_dir holds an unused code");

  // Cursor and button move only on a completed packet
  a_cursor_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && $past(out_beat) && !packet_done_i |->
      cursor_x_i == $past(cursor_x_i) && cursor_y_i == $past(cursor_y_i)
      && left_pressed_i == $past(left_pressed_i))
    else $error("cursor changed without a completed packet");

endmodule

bind ps2_mouse_packet_tracker_top ps2mt_checker u_ps2mt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .packet_done_i  (result_o.packet_done),
  .byte_dropped_i (result_o.byte_dropped),
  .cursor_x_i     (result_o.cursor_x),
  .cursor_y_i     (result_o.cursor_y),
  .left_pressed_i (result_o.left_pressed),
  .scroll_dir_i   (result_o.scroll_dir)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_packet_tracker_top: drives byte beats and
// register writes, predicts every result beat and checks it. Needs ps2mt_pkg and ps2mt_ifs.
module tb;
  import ps2mt_pkg::*;

  localparam logic [7:0] ST_FULL    = 8'(1 << ST_FULL_BIT);
  localparam logic [7:0] ST_AUX     = 8'(1 << ST_AUX_BIT);
  localparam logic [7:0] ST_TAKE    = ST_FULL | ST_AUX;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         PHASE_BYTES = 155;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic                   done;
    logic                   dropped;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic                   left;
    logic [1:0]             scroll;
  } cursor_report_t;

  // Cursor predictor and report checker
  class mouse_track_sb;
    logic                   ext_mode;
    logic [SIZE_WIDTH-1:0]  width_cfg;
    logic [SIZE_WIDTH-1:0]  height_cfg;
    logic [1:0]             byte_idx;
    logic [7:0]             pkt_bytes[3];
    logic [COORD_WIDTH-1:0] cur_x;
    logic [COORD_WIDTH-1:0] cur_y;
    logic                   left_btn;
    logic [1:0]             wheel;
    cursor_report_t         due_reports[$];
    int                     errors;

    function new();
      ext_mode   = 1'b0;
      width_cfg  = RST_VIEW_WIDTH;
      height_cfg = RST_VIEW_HEIGHT;
      byte_idx   = POS_FIRST;
      pkt_bytes  = '{default: '0};
      cur_x      = RST_POS_X;
      cur_y      = RST_POS_Y;
      left_btn   = 1'b0;
      wheel      = SCROLL_NONE;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [SIZE_WIDTH-1:0] v);
      case (idx)
        CFG_EXTENDED_MODE: ext_mode = v[0];
        CFG_VIEW_WIDTH:    width_cfg = v;
        CFG_VIEW_HEIGHT:   height_cfg = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // size 0 pins the axis at 0; the top is capped at the coordinate range
    function logic [COORD_WIDTH-1:0] pin_to_screen(int v, logic [SIZE_WIDTH-1:0] size);
      int lim;
      lim = (size == 0) ? 0 : int'(size) - 1;
      if (lim > (1 << COORD_WIDTH) - 1) lim = (1 << COORD_WIDTH) - 1;
      if (v < 0) return '0;
      if (v > lim) return COORD_WIDTH'(lim);
      return COORD_WIDTH'(v);
    endfunction

    function void take_byte(logic [7:0] st, logic [7:0] dat);
      cursor_report_t rep;
      int             last;
      int             dx;
      int             dy;
      logic [7:0]     y_byte;
      rep.done    = 1'b0;
      rep.dropped = 1'b0;
      if (st[ST_FULL_BIT] && st[ST_AUX_BIT]) begin
        last = ext_mode ? int'(POS_LAST_WHEEL) : int'(POS_LAST_STD);
        if (byte_idx == POS_FIRST && !dat[B0_SYNC_BIT]) begin
          rep.dropped = 1'b1;
        end else if (int'(byte_idx) < last) begin
          pkt_bytes[byte_idx] = dat;
          byte_idx = byte_idx + 2'd1;
        end else begin
          // standard mode uses the completing byte as Y, even after a mode switch
          y_byte = ext_mode ? pkt_bytes[2] : dat;
          dx = int'(pkt_bytes[1]);
          if (pkt_bytes[0][B0_XSIGN_BIT]) dx -= 256;
          dy = int'(y_byte);
          if (pkt_bytes[0][B0_YSIGN_BIT]) dy -= 256;
          rep.done = 1'b1;
          byte_idx = POS_FIRST;
          left_btn = pkt_bytes[0][B0_LEFT_BIT];
          if (ext_mode) begin
            if (dat[3:0] == WHEEL_UP_NIB) wheel = SCROLL_UP;
            else if (dat[3:0] == WHEEL_DOWN_NIB) wheel = SCROLL_DOWN;
          end
          cur_x = pin_to_screen(int'(cur_x) + dx, width_cfg);
          cur_y = pin_to_screen(int'(cur_y) - dy, height_cfg);
        end
      end
      rep.x      = cur_x;
      rep.y      = cur_y;
      rep.left   = left_btn;
      rep.scroll = wheel;
      due_reports.push_back(rep);
    endfunction

    function void match_report(cursor_report_t got);
      cursor_report_t want;
      if (due_reports.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
        return;
      end
      want = due_reports.pop_front();
      if (got.done !== want.done) begin
        $error("packet_done: expected %0d, got %0d", want.done, got.done);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("byte_dropped: expected %0d, got %0d", want.dropped, got.dropped);
        errors++;
      end
      if (got.x !== want.x) begin
        $error("cursor_x: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("cursor_y: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.left !== want.left) begin
        $error("left_pressed: expected %0d, got %0d", want.left, got.left);
        errors++;
      end
      if (got.scroll !== want.scroll) begin
        $error("scroll_dir: expected %0d, got %0d", $signed(want.scroll),
               $signed(got.scroll));
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i;

  ps2mt_byte_if   byte_if ();
  ps2mt_result_if res_if ();

  ps2_mouse_packet_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mouse_track_sb sb;
  int burst_left;
  int ready_left;
  int idle_cycles;

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: long and short ready stretches mixed with short and longer stalls
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin res_if.ready <= 1'b1; ready_left = $urandom_range(20, 80); end
        1: begin res_if.ready <= 1'b0; ready_left = $urandom_range(1, 10); end
        2: begin res_if.ready <= 1'b1; ready_left = $urandom_range(1, 4); end
        default: begin res_if.ready <= 1'b0; ready_left = $urandom_range(1, 2); end
      endcase
    end else begin
      ready_left--;
    end
  end

  // Monitor: predict on input beats, check result beats, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready)
        sb.take_byte(byte_if.status_byte, byte_if.data_byte);
      if (res_if.valid && res_if.ready)
        sb.match_report('{done: res_if.packet_done, dropped: res_if.byte_dropped,
                          x: res_if.cursor_x, y: res_if.cursor_y,
                          left: res_if.left_pressed, scroll: res_if.scroll_dir});
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Send one beat; the sender idles between bursts of random length
  task automatic push_byte(input logic [7:0] st, input logic [7:0] dat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    byte_if.valid       <= 1'b1;
    byte_if.status_byte <= st;
    byte_if.data_byte   <= dat;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  // Drain every outstanding beat, then let the pipeline settle
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic ext, input logic [SIZE_WIDTH-1:0] w,
                               input logic [SIZE_WIDTH-1:0] h);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_EXTENDED_MODE;
    cfg_data_i <= CFG_DATA_WIDTH'(ext);
    sb.set_reg(CFG_EXTENDED_MODE, SIZE_WIDTH'(ext));
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VIEW_WIDTH;
    cfg_data_i <= w;
    sb.set_reg(CFG_VIEW_WIDTH, w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VIEW_HEIGHT;
    cfg_data_i <= h;
    sb.set_reg(CFG_VIEW_HEIGHT, h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Status that the block must ignore, with all other bits random
  function automatic logic [7:0] ignored_status();
    logic [7:0] st;
    st = 8'($urandom);
    if ($urandom_range(0, 1) == 1) st[ST_FULL_BIT] = 1'b0;
    else st[ST_AUX_BIT] = 1'b0;
    return st;
  endfunction

  // Mostly well-formed packets, some stray status, some unsynced first bytes
  task automatic random_traffic(input int n);
    int         sent;
    int         kind;
    int         len;
    logic [7:0] st;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        len = sb.ext_mode ? 4 : 3;
        for (int i = 0; i < len; i++) begin
          st = 8'($urandom) | ST_TAKE;
          b  = 8'($urandom);
          if (i == 0) b[B0_SYNC_BIT] = 1'b1;
          if (i == 3) begin
            case ($urandom_range(0, 2))
              0: b[3:0] = WHEEL_UP_NIB;
              1: b[3:0] = WHEEL_DOWN_NIB;
              default: ;
            endcase
          end
          push_byte(st, b);
          sent++;
          if ($urandom_range(0, 15) == 0) push_byte(ignored_status(), 8'($urandom));
        end
      end else if (kind < 17) begin
        st = 8'($urandom);
        push_byte(st, 8'($urandom));
        if (st[ST_FULL_BIT] && st[ST_AUX_BIT]) sent++;
      end else begin
        b = 8'($urandom);
        b[B0_SYNC_BIT] = 1'b0;
        push_byte(8'($urandom) | ST_TAKE, b);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    burst_left  = 0;
    ready_left  = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_EXTENDED_MODE;
    cfg_data_i = '0;
    byte_if.valid       = 1'b0;
    byte_if.status_byte = '0;
    byte_if.data_byte   = '0;
    res_if.ready        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Status filtering and an unsynced first byte, at reset settings
    push_byte(8'h00, 8'hFF);
    push_byte(ST_FULL, 8'h08);
    push_byte(ST_AUX, 8'h08);
    push_byte(8'hFF, 8'h00);
    // Largest positive X, zero Y
    push_byte(ST_TAKE, 8'h08);
    push_byte(ST_TAKE, 8'hFF);
    push_byte(8'hFF, 8'h00);
    // Most negative deltas with left held: X runs into 0, Y into the bottom edge
    repeat (3) begin
      push_byte(ST_TAKE, 8'h39);
      push_byte(ignored_status(), 8'h08);
      push_byte(ST_TAKE, 8'h00);
      push_byte(ST_TAKE, 8'h00);
    end
    // Largest positive both, button released
    push_byte(ST_TAKE, 8'h08);
    push_byte(ST_TAKE, 8'hFF);
    push_byte(ST_TAKE, 8'hFF);
    // Switch to wheel packets with two bytes already in
    push_byte(ST_TAKE, 8'h18);
    push_byte(ST_TAKE, 8'h80);
    apply_setting(1'b1, 13'd4096, 13'd4096);
    push_byte(ST_TAKE, 8'h7F);
    push_byte(ST_TAKE, 8'h01);
    // Wheel down, then a nibble that keeps the direction
    push_byte(ST_TAKE, 8'h08);
    push_byte(ST_TAKE, 8'h10);
    push_byte(ST_TAKE, 8'h20);
    push_byte(ST_TAKE, 8'hFF);
    push_byte(ST_TAKE, 8'h08);
    push_byte(ST_TAKE, 8'h00);
    push_byte(ST_TAKE, 8'h00);
    push_byte(ST_TAKE, 8'h07);
    // Back to standard mode with three bytes held: the next byte completes as Y
    push_byte(ST_TAKE, 8'h09);
    push_byte(ST_TAKE, 8'h01);
    push_byte(ST_TAKE, 8'h01);
    apply_setting(1'b0, 13'd4096, 13'd4096);
    push_byte(ST_TAKE, 8'h05);

    // Random phases over a spread of settings, extremes included
    apply_setting(1'b1, 13'd4096, 13'd4096);
    random_traffic(PHASE_BYTES);
    apply_setting(1'b0, 13'd1, 13'd1);
    random_traffic(PHASE_BYTES);
    apply_setting(1'b1, 13'd0, 13'd8191);
    random_traffic(PHASE_BYTES);
    apply_setting(1'b0, 13'd8191, 13'd0);
    random_traffic(PHASE_BYTES);
    apply_setting(1'b1, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    random_traffic(PHASE_BYTES);
    apply_setting(1'b0, 13'd800, 13'd600);
    random_traffic(PHASE_BYTES);

    settle();
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== ps2_mouse_packet_tracker_top.f =====
src/ps2mt_pkg.sv
src/ps2mt_ifs.sv
src/ps2mt_cfg_regs.sv
src/ps2mt_in_stage.sv
src/ps2mt_tracker.sv
src/ps2_mouse_packet_tracker_top.sv
src/ps2mt_checker.sv
verif/tb.sv
